/* rtl/core/salc_pkg.sv */
// Package: shared constants and types for the set-associative LRU cache core
package salc_pkg;
	localparam int MAX_SETS_D  = 64;
	localparam int MAX_WAYS_D  = 8;
	localparam int ADDR_BITS_D = 32;
	localparam int CFG_W       = 4;

	localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] REG_SET_BITS    = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_EVAL  = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction
endpackage

/* rtl/core/salc_tag_ram.sv */
// Module: per-set tag, stamp, valid and dirty memory, one whole set per row, registered read
module salc_tag_ram
	import salc_pkg::*;
#(
	parameter int SETS = MAX_SETS_D,
	parameter int WAYS = MAX_WAYS_D,
	parameter int TW   = ADDR_BITS_D
) (
	input  logic                                   clk,
	input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] rd_set,
	output logic [WAYS-1:0][TW-1:0]                rd_tag,
	output logic [WAYS-1:0][31:0]                  rd_stamp,
	output logic [WAYS-1:0]                        rd_valid,
	output logic [WAYS-1:0]                        rd_dirty,
	input  logic                                   wr_en,
	input  logic                                   fl_en,
	input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] wr_set,
	input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] wr_way,
	input  logic [TW-1:0]                          wr_tag,
	input  logic [31:0]                            wr_stamp,
	input  logic [WAYS-1:0]                        wr_valid,
	input  logic [WAYS-1:0]                        wr_dirty
);
	logic [WAYS-1:0][TW-1:0] tag_mem [SETS];
	logic [WAYS-1:0][31:0]   stamp_mem [SETS];
	logic [WAYS-1:0]         valid_mem [SETS];
	logic [WAYS-1:0]         dirty_mem [SETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_set][wr_way]   <= wr_tag;
			stamp_mem[wr_set][wr_way] <= wr_stamp;
		end
		if (fl_en) begin
			valid_mem[wr_set] <= wr_valid;
			dirty_mem[wr_set] <= wr_dirty;
		end
		rd_tag   <= tag_mem[rd_set];
		rd_stamp <= stamp_mem[rd_set];
		rd_valid <= valid_mem[rd_set];
		rd_dirty <= dirty_mem[rd_set];
	end
endmodule

/* rtl/core/set_assoc_lru_writeback_cache_core.sv */
// Top level: set-associative write-back, write-allocate cache tag core with LRU
//  channel  | signals                                   | handshake
//  access   | operation, address                        | start & !busy
//  result   | hit, way, victim_dirty, *_misses, writebacks | done (one cycle)
//  config   | cfg_we, cfg_index, cfg_wdata              | cfg_we
// After a transfer the set row is read in the next cycle, then compare, victim
// pick and write back follow in the cycle after; done is high in the cycle after
// that, and a new transfer can be taken at the edge ending done.
// After reset a clearing pass zeroes the valid and dirty rows of all MAX_SETS sets
// (64 by default), one set per cycle, with busy high. One access at a time avoids
// overlap on the set memory. The receiver cannot stall: done pulses for one cycle.
module set_assoc_lru_writeback_cache_core
	import salc_pkg::*;
#(
	parameter int MAX_SETS  = MAX_SETS_D,
	parameter int MAX_WAYS  = MAX_WAYS_D,
	parameter int ADDR_BITS = ADDR_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [31:0] address,
	output logic        done,
	output logic        hit,
	output logic [2:0]  way,
	output logic        victim_dirty,
	output logic [31:0] load_misses,
	output logic [31:0] store_misses,
	output logic [31:0] writebacks,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);
	localparam int SW  = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
	localparam int WW  = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int AW  = ADDR_BITS < 32 ? ADDR_BITS : 32;
	localparam int SFL = $clog2(MAX_SETS + 1) - 1;
	localparam int SBM = SFL > 7 ? 7 : SFL;

	state_t state_q;
	logic [2:0] offset_bits_q, set_bits_q;
	logic [3:0] ways_in_use_q;
	logic [31:0] clock_q, lm_q, sm_q, wb_q;
	logic [SW-1:0] clr_q;
	logic op_q;
	logic [SW-1:0] set_q;
	logic [31:0] tag_q;

	logic [2:0] sb, ob;
	logic [3:0] ways;
	logic [31:0] addr_m, block;
	logic [SW-1:0] set_c;
	logic [31:0] tag_c;
	logic [MAX_WAYS-1:0][31:0] rd_tag, rd_stamp;
	logic [MAX_WAYS-1:0] rd_valid, rd_dirty, vrow, drow;

	always_comb begin
		sb = (set_bits_q > 3'(SBM)) ? 3'(SBM) : set_bits_q;
		ob = offset_bits_q;
		ways = (ways_in_use_q == 4'd0) ? 4'd1 : ways_in_use_q;
		if (MAX_WAYS < 16 && ways > 4'(MAX_WAYS)) ways = 4'(MAX_WAYS);
		addr_m = address & (32'hFFFF_FFFF >> (32 - AW));
		block = addr_m >> ob;
		set_c = SW'(block & ((32'd1 << sb) - 32'd1));
		tag_c = block >> sb;
	end

	// way scan and LRU pick over the registered row
	logic hit_c, free_c;
	logic [WW-1:0] hway, fway, lway, wsel;
	logic [31:0] best;
	always_comb begin
		hit_c = 1'b0; free_c = 1'b0; hway = '0; fway = '0; lway = '0;
		best = clock_q - rd_stamp[0];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (4'(w) < ways) begin
				if (rd_valid[w]) begin
					if (rd_tag[w] == tag_q && !hit_c) begin
						hit_c = 1'b1; hway = WW'(w);
					end
				end else if (!free_c) begin
					free_c = 1'b1; fway = WW'(w);
				end
				if (w > 0 && (clock_q - rd_stamp[w]) > best) begin
					best = clock_q - rd_stamp[w]; lway = WW'(w);
				end
			end
		end
		wsel = hit_c ? hway : (free_c ? fway : lway);
	end

	always_comb begin
		vrow = rd_valid;
		drow = rd_dirty;
		vrow[wsel] = 1'b1;
		if (hit_c) begin
			if (op_q == OP_STORE) drow[wsel] = 1'b1;
		end else begin
			drow[wsel] = (op_q == OP_STORE);
		end
	end

	logic wr_en, vd_c, clearing;
	assign wr_en    = (state_q == ST_EVAL);
	assign clearing = (state_q == ST_CLEAR);
	assign vd_c     = !hit_c && !free_c && rd_dirty[lway];

	salc_tag_ram #(.SETS(MAX_SETS), .WAYS(MAX_WAYS), .TW(32)) u_ram (
		.clk(clk), .rd_set(set_q), .rd_tag(rd_tag), .rd_stamp(rd_stamp),
		.rd_valid(rd_valid), .rd_dirty(rd_dirty),
		.wr_en(wr_en), .fl_en(wr_en || clearing),
		.wr_set(clearing ? clr_q : set_q), .wr_way(wsel),
		.wr_tag(hit_c ? rd_tag[wsel] : tag_q), .wr_stamp(clock_q),
		.wr_valid(clearing ? '0 : vrow), .wr_dirty(clearing ? '0 : drow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			offset_bits_q <= 3'd2; set_bits_q <= 3'd0; ways_in_use_q <= 4'd1;
			clock_q <= '0; lm_q <= '0; sm_q <= '0; wb_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_BITS: offset_bits_q <= cfg_wdata[2:0];
					REG_SET_BITS:    set_bits_q    <= cfg_wdata[2:0];
					REG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(MAX_SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (start) state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					clock_q <= clock_q + 32'd1;
					if (!hit_c) begin
						if (op_q == OP_STORE) sm_q <= sat_inc(sm_q);
						else lm_q <= sat_inc(lm_q);
						if (vd_c) wb_q <= sat_inc(wb_q);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q <= operation; set_q <= set_c; tag_q <= tag_c;
		end
		if (state_q == ST_EVAL) begin
			hit <= hit_c; way <= 3'(wsel); victim_dirty <= vd_c;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign load_misses = lm_q;
	assign store_misses = sm_q;
	assign writebacks = wb_q;

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |=> done) else $error("done missing");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("start not taken");
	a_wb_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !victim_dirty) else $error("writeback on hit");
endmodule

/* tb/sv/set_assoc_lru_writeback_cache_core_chk.sv */
// Checker: predicts cache access results and compares them with the core's outputs
`timescale 1ns / 100ps
module set_assoc_lru_writeback_cache_core_chk
	import salc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic        done,
	input  logic        hit,
	input  logic [2:0]  way,
	input  logic        victim_dirty,
	input  logic [31:0] load_misses,
	input  logic [31:0] store_misses,
	input  logic [31:0] writebacks,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int          errors,
	output int          pending
);
	localparam int LINES = MAX_SETS_D * MAX_WAYS_D;

	typedef struct {
		logic        hit;
		logic [2:0]  way;
		logic        victim_dirty;
		logic [31:0] load_misses;
		logic [31:0] store_misses;
		logic [31:0] writebacks;
	} access_result_t;

	access_result_t result_q[$];

	logic [2:0]  offset_bits_m;
	logic [2:0]  set_bits_m;
	logic [3:0]  ways_m;
	logic [31:0] tag_m   [LINES];
	logic        valid_m [LINES];
	logic        dirty_m [LINES];
	logic [31:0] stamp_m [LINES];
	logic [31:0] now_m;
	logic [31:0] lmiss_m, smiss_m, wback_m;

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic predict_access(input logic op, input logic [31:0] addr);
		int sb, nways, base, w, hit_way, free_way, idx;
		logic [31:0] blk, tg, setn, best, age;
		logic found, have_free;
		access_result_t r;
		sb = set_bits_m;
		while (sb > 0 && (1 << sb) > MAX_SETS_D) sb--;
		nways = ways_m;
		if (nways == 0) nways = 1;
		if (nways > MAX_WAYS_D) nways = MAX_WAYS_D;
		blk = addr >> offset_bits_m;
		setn = blk & ((32'd1 << sb) - 32'd1);
		tg = blk >> sb;
		base = setn * MAX_WAYS_D;
		found = 0;
		have_free = 0;
		hit_way = 0;
		free_way = 0;
		r.victim_dirty = 0;
		for (w = 0; w < nways; w++) begin
			if (valid_m[base + w]) begin
				if (tag_m[base + w] == tg) begin
					found = 1;
					hit_way = w;
					break;
				end
			end else if (!have_free) begin
				have_free = 1;
				free_way = w;
			end
		end
		if (found) begin
			idx = base + hit_way;
			stamp_m[idx] = now_m;
			if (op == OP_STORE) dirty_m[idx] = 1;
		end else begin
			if (op == OP_STORE) smiss_m = bump(smiss_m);
			else lmiss_m = bump(lmiss_m);
			if (have_free) begin
				hit_way = free_way;
			end else begin
				best = now_m - stamp_m[base];
				hit_way = 0;
				for (w = 1; w < nways; w++) begin
					age = now_m - stamp_m[base + w];
					if (age > best) begin
						best = age;
						hit_way = w;
					end
				end
				if (dirty_m[base + hit_way]) begin
					r.victim_dirty = 1;
					wback_m = bump(wback_m);
				end
			end
			idx = base + hit_way;
			valid_m[idx] = 1;
			tag_m[idx] = tg;
			stamp_m[idx] = now_m;
			dirty_m[idx] = (op == OP_STORE);
		end
		now_m = now_m + 32'd1;
		r.hit = found;
		r.way = hit_way[2:0];
		r.load_misses = lmiss_m;
		r.store_misses = smiss_m;
		r.writebacks = wback_m;
		result_q.push_back(r);
	endtask

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		access_result_t e;
		if (!arst_n) begin
			offset_bits_m = 3'd2;
			set_bits_m = 3'd0;
			ways_m = 4'd1;
			for (int i = 0; i < LINES; i++) begin
				valid_m[i] = 0;
				dirty_m[i] = 0;
				tag_m[i] = '0;
				stamp_m[i] = '0;
			end
			now_m = '0;
			lmiss_m = '0;
			smiss_m = '0;
			wback_m = '0;
			result_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_BITS: offset_bits_m = cfg_wdata[2:0];
					REG_SET_BITS:    set_bits_m = cfg_wdata[2:0];
					REG_WAYS_IN_USE: ways_m = cfg_wdata[3:0];
					default: ;
				endcase
			end
			if (done) begin
				if (result_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = result_q.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit);
						errors++;
					end
					if (way !== e.way) begin
						$error("way: expected %0d, got %0d", e.way, way);
						errors++;
					end
					if (victim_dirty !== e.victim_dirty) begin
						$error("victim_dirty: expected %0d, got %0d", e.victim_dirty,
							victim_dirty);
						errors++;
					end
					if (load_misses !== e.load_misses) begin
						$error("load_misses: expected %0d, got %0d", e.load_misses,
							load_misses);
						errors++;
					end
					if (store_misses !== e.store_misses) begin
						$error("store_misses: expected %0d, got %0d", e.store_misses,
							store_misses);
						errors++;
					end
					if (writebacks !== e.writebacks) begin
						$error("writebacks: expected %0d, got %0d", e.writebacks,
							writebacks);
						errors++;
					end
				end
			end
			if (start && !busy) predict_access(operation, address);
		end
	end
endmodule

/* tb/sv/set_assoc_lru_writeback_cache_core_tb.sv */
// Testbench top: drives accesses and register writes into the cache core and reports the verdict
`timescale 1ns / 100ps
module set_assoc_lru_writeback_cache_core_tb;
	import salc_pkg::*;

	localparam int LIMIT = 300000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic operation = OP_LOAD;
	logic [31:0] address = '0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_OFFSET_BITS;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic busy, done, hit, victim_dirty;
	logic [2:0] way;
	logic [31:0] load_misses, store_misses, writebacks;
	int errors, pending;
	int cycles = 0;
	int idle_pct;
	logic [31:0] tag_pool[8];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	set_assoc_lru_writeback_cache_core dut (.*);

	set_assoc_lru_writeback_cache_core_chk chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called at a falling edge; leaves start high after the transfer
	task automatic issue_access(input logic op, input logic [31:0] addr);
		while (busy) begin
			start = 0;
			@(negedge clk);
		end
		start = 1;
		operation = op;
		address = addr;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		start = 0;
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain;
		start = 0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	initial begin
		logic [3:0] cfg_set[7][3];
		logic [31:0] a;
		cfg_set = '{'{2, 0, 1}, '{0, 0, 8}, '{14, 6, 8}, '{3, 2, 4},
			'{8, 7, 0}, '{1, 3, 15}, '{4, 6, 2}};
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// reset geometry: one way, one set
		issue_access(OP_LOAD, 32'h0);
		issue_access(OP_STORE, 32'h0);
		issue_access(OP_LOAD, 32'h4);
		issue_access(OP_STORE, 32'hFFFF_FFFF);
		issue_access(OP_LOAD, 32'hFFFF_FFFF);
		issue_access(OP_STORE, 32'h8000_0000);
		issue_access(OP_STORE, 32'h0000_0003);
		drain();
		write_reg(REG_WAYS_IN_USE, 4'd2);
		issue_access(OP_STORE, 32'h10);
		issue_access(OP_LOAD, 32'h20);
		issue_access(OP_LOAD, 32'h10);
		issue_access(OP_LOAD, 32'h30);
		issue_access(OP_LOAD, 32'h40);
		issue_access(OP_STORE, 32'h7FFF_FFFF);
		drain();
		write_reg(3, 4'hF);
		for (int p = 0; p < 7; p++) begin
			write_reg(REG_OFFSET_BITS, cfg_set[p][0]);
			write_reg(REG_SET_BITS, cfg_set[p][1]);
			write_reg(REG_WAYS_IN_USE, cfg_set[p][2]);
			idle_pct = (p < 3) ? 27 : (p < 5) ? 48 : 0;
			for (int k = 0; k < 8; k++) tag_pool[k] = $urandom;
			for (int n = 0; n < 72; n++) begin
				while ($urandom_range(0, 99) < idle_pct) begin
					start = 0;
					@(negedge clk);
				end
				if ($urandom_range(0, 99) < 15) a = $urandom;
				else a = tag_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 1023);
				issue_access(1'($urandom_range(0, 1)), a);
			end
			drain();
		end
		start = 0;
		drain();
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
